// File: hw/rtl/esc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the encoder stillness calibrator.
// Used by esc_ctrl, esc_dpath, the top level and the checker; depends on nothing.
package esc_pkg;

	// Depth of the sample window. Must be a power of two.
	localparam int WINDOW = 16;
	localparam int WIN_AW = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = 32 + WIN_AW;
	localparam int PROD_W = 50;

	localparam logic [1:0] MODE_UNINIT = 2'd0;
	localparam logic [1:0] MODE_CAL    = 2'd1;
	localparam logic [1:0] MODE_SEEK   = 2'd2;
	localparam logic [1:0] MODE_HOLD   = 2'd3;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_CAL  = 2'd1;
	localparam logic [1:0] CMD_GOTO = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_QUICK  = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic walk_start;
		logic walk;
		logic take_quick;
		logic take_mean;
		logic load_target;
		logic mul;
		logic rnd;
	} esc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_last;
		logic still;
		logic fill_nz;
	} esc_stat_t;

endpackage

// File: hw/rtl/esc_dpath.sv
`timescale 1ns / 1ps
// Datapath: sample window memory, min/max/sum walk, base and target
// registers, and the height multiply, round and saturate. Uses esc_pkg.
module esc_dpath import esc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  esc_cmd_t           cmd,
	output esc_stat_t          stat,
	input  logic signed [31:0] in_count,
	input  logic signed [23:0] in_target,
	input  logic [15:0]        still_threshold,
	input  logic [15:0]        inches_per_tick_q16,
	input  logic signed [23:0] bottom_offset_q8,
	output logic signed [31:0] height_sat,
	output logic signed [23:0] target
);

	localparam logic signed [SUM_W-1:0] MEAN_ADJ = SUM_W'(WINDOW - 1);
	localparam logic [WIN_AW-1:0] LAST_IDX = WIN_AW'(WINDOW - 1);

	logic signed [31:0]       win_mem [WINDOW];
	logic signed [31:0]       rd_data_s1;
	logic                     rd_vld_s1;
	logic                     rd_in_s1;
	logic [WIN_AW-1:0]        wp_q;
	logic [WIN_AW-1:0]        widx_q;
	logic [FILL_W-1:0]        fill_q;
	logic signed [31:0]       newest_q;
	logic signed [31:0]       base_q;
	logic signed [23:0]       target_q;
	logic signed [31:0]       min_q;
	logic signed [31:0]       max_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [41:0]       rnd_s2;

	logic signed [31:0]       entry;
	logic signed [32:0]       spread;
	logic signed [SUM_W-1:0]  sum_adj;
	logic signed [SUM_W-1:0]  mean_full;
	logic signed [32:0]       diff;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [42:0]       hsum;

	// Window memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_mem[wp_q] <= in_count;
		end
		rd_data_s1 <= win_mem[widx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			fill_q    <= '0;
			widx_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_in_s1  <= 1'b0;
			base_q    <= '0;
			target_q  <= '0;
		end else begin
			if (cmd.push) begin
				wp_q <= wp_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.walk_start) begin
				widx_q <= '0;
			end else if (cmd.walk) begin
				widx_q <= widx_q + 1'b1;
			end
			rd_vld_s1 <= cmd.walk;
			rd_in_s1  <= {1'b0, widx_q} < fill_q;
			if (cmd.take_quick) begin
				base_q <= in_count;
			end else if (cmd.take_mean) begin
				base_q <= mean_full[31:0];
			end
			if (cmd.load_target) begin
				target_q <= in_target;
			end
		end
	end

	// Entries never written since reset read as zero.
	assign entry = rd_in_s1 ? rd_data_s1 : 32'sd0;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			newest_q <= in_count;
		end
		if (cmd.walk_start) begin
			min_q <= 32'sh7FFF_FFFF;
			max_q <= -32'sh8000_0000;
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			if (entry < min_q) begin
				min_q <= entry;
			end
			if (entry > max_q) begin
				max_q <= entry;
			end
			sum_q <= sum_q + SUM_W'(entry);
		end
		if (cmd.mul) begin
			prod_s1 <= diff * $signed({1'b0, inches_per_tick_q16});
		end
		if (cmd.rnd) begin
			rnd_s2 <= prod_rnd[PROD_W-1:8];
		end
	end

	assign spread = {max_q[31], max_q} - {min_q[31], min_q};

	// Mean truncates toward zero: bias negative sums before the shift.
	assign sum_adj   = sum_q[SUM_W-1] ? (sum_q + MEAN_ADJ) : sum_q;
	assign mean_full = sum_adj >>> WIN_AW;

	assign diff     = {newest_q[31], newest_q} - {base_q[31], base_q};
	assign prod_rnd = prod_s1 + PROD_W'(128);
	assign hsum     = {rnd_s2[41], rnd_s2} + 43'(bottom_offset_q8);

	always_comb begin
		if (hsum[42:31] == {12{hsum[42]}}) begin
			height_sat = hsum[31:0];
		end else if (hsum[42]) begin
			height_sat = 32'sh8000_0000;
		end else begin
			height_sat = 32'sh7FFF_FFFF;
		end
	end

	assign stat.walk_last = (widx_q == LAST_IDX);
	assign stat.still     = spread < $signed({17'b0, still_threshold});
	assign stat.fill_nz   = (fill_q != '0);
	assign target         = target_q;

endmodule

// File: hw/rtl/esc_ctrl.sv
`timescale 1ns / 1ps
// Controller: operating mode, calibration flag, brake, and the sequencer
// that steps the datapath through one word. Uses esc_pkg.
module esc_ctrl import esc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_cmd,
	input  logic       quick_mode,
	input  esc_stat_t  stat,
	input  logic       out_free,
	output logic       out_load,
	output esc_cmd_t   cmd,
	output logic [1:0] mode,
	output logic       calibrated,
	output logic       brake
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_RND    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] mode_q;
	logic       cal_q;
	logic       brake_q;
	logic       accept;
	logic       tick;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (in_cmd == CMD_TICK);

	always_comb begin
		cmd             = '0;
		cmd.push        = tick;
		cmd.walk_start  = tick && (mode_q == MODE_CAL) && !quick_mode;
		cmd.take_quick  = tick && (mode_q == MODE_CAL) && quick_mode;
		cmd.load_target = accept && (in_cmd == CMD_GOTO) && (mode_q inside {MODE_SEEK, MODE_HOLD});
		cmd.walk        = (state_q == ST_WALK);
		cmd.take_mean   = (state_q == ST_DECIDE) && stat.still;
		cmd.mul         = (state_q == ST_MUL);
		cmd.rnd         = (state_q == ST_RND);
	end

	assign out_load = (state_q == ST_FIN) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = cmd.walk_start ? ST_WALK : ST_MUL;
				end
			end
			ST_WALK: begin
				if (stat.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_MUL;
			ST_MUL:    state_d = ST_RND;
			ST_RND:    state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_UNINIT;
			cal_q   <= 1'b0;
			brake_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (tick) begin
				case (mode_q)
					MODE_UNINIT: brake_q <= 1'b1;
					MODE_HOLD:   brake_q <= 1'b1;
					MODE_CAL:    brake_q <= 1'b0;
					default:     brake_q <= brake_q;
				endcase
			end
			if (cmd.take_quick || cmd.take_mean) begin
				cal_q  <= 1'b1;
				mode_q <= MODE_HOLD;
			end else if (accept && (in_cmd == CMD_CAL)) begin
				mode_q <= MODE_CAL;
			end else if (cmd.load_target) begin
				mode_q <= MODE_SEEK;
			end
		end
	end

	assign mode       = mode_q;
	assign calibrated = cal_q;
	assign brake      = brake_q;

endmodule

// File: hw/rtl/encoder_stillness_calibrator.sv
`timescale 1ns / 1ps
// Encoder stillness calibrator. The input stream carries one command word per
// control tick: a tick with a raw encoder count, a start-calibration request or
// a height request, with the command code in s_tuser. Every accepted word gives
// exactly one status word on the output stream: mode, calibrated, brake,
// motor stop, the Q24.8 height of the newest count and the stored target.
// Configuration is written through cfg_we/cfg_addr/cfg_data; the user must
// write it only while idle, as the block does not enforce this. An accepted
// word passes the multiply, round and final steps; the final step loads the
// output register, raising m_tvalid as the sequencer returns to idle. A tick
// while calibrating without quick mode first walks the 16-entry window memory
// one entry per cycle for min, max and sum, paced by its single read port. One
// word is in work at a time; s_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new input word is accepted
// while the previous result still waits for m_tready. A further result waits
// in its final step until that register is free; nothing is dropped.
// Reset (arst_n low) clears the mode to uninitialized, applies the brake,
// empties the window, zeroes base and target, and restores the register
// defaults: quick mode off, threshold 16, 1024/65536 inch per tick, offset 0.
// Dependencies: esc_pkg, esc_ctrl, esc_dpath.
module encoder_stillness_calibrator import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // encoder_count[31:0], target_height[55:32]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // mode[1:0], calibrated[2], brake_on[3],
	                               // motor_stop[4], height[36:5], target[60:37], zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_data
);

	logic               quick_q;
	logic [15:0]        thresh_q;
	logic [15:0]        scale_q;
	logic signed [23:0] offset_q;

	esc_cmd_t           dp_cmd;
	esc_stat_t          dp_stat;
	logic               out_free;
	logic               out_load;
	logic [1:0]         mode;
	logic               calibrated;
	logic               brake;
	logic signed [31:0] height_sat;
	logic signed [23:0] target;
	logic signed [31:0] height;
	logic               motor_stop;
	logic               out_vld_q;
	logic [63:0]        out_data_q;

	// Configuration registers; a write takes effect at the clock edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quick_q  <= 1'b0;
			thresh_q <= 16'd16;
			scale_q  <= 16'd1024;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_QUICK:  quick_q  <= cfg_data[0];
				REG_THRESH: thresh_q <= cfg_data[15:0];
				REG_SCALE:  scale_q  <= cfg_data[15:0];
				REG_OFFSET: offset_q <= cfg_data;
				default:    quick_q  <= quick_q;
			endcase
		end
	end

	esc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.quick_mode (quick_q),
		.stat       (dp_stat),
		.out_free   (out_free),
		.out_load   (out_load),
		.cmd        (dp_cmd),
		.mode       (mode),
		.calibrated (calibrated),
		.brake      (brake)
	);

	esc_dpath u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (dp_cmd),
		.stat                (dp_stat),
		.in_count            (s_tdata[31:0]),
		.in_target           (s_tdata[55:32]),
		.still_threshold     (thresh_q),
		.inches_per_tick_q16 (scale_q),
		.bottom_offset_q8    (offset_q),
		.height_sat          (height_sat),
		.target              (target)
	);

	// Height reads as zero until a base exists and the window holds a count.
	assign height     = (calibrated && dp_stat.fill_nz) ? height_sat : 32'sd0;
	assign motor_stop = (mode == MODE_UNINIT) || (mode == MODE_HOLD);

	// Output register: free when empty or being taken this cycle.
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b000, target, height, motor_stop, brake, calibrated, mode};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// File: hw/rtl/esc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the encoder stillness calibrator, bound to the top
// level below. Uses esc_pkg for the mode codes.
module esc_checker import esc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// A stalled result word holds its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Motor stop follows the reported mode.
	a_motor_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4] ==
			((m_tdata[1:0] == MODE_UNINIT) || (m_tdata[1:0] == MODE_HOLD))))
		else $error("motor stop disagrees with mode");

	// Without a base, the height reads zero.
	a_uncal_height: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> (m_tdata[36:5] == 32'd0))
		else $error("height nonzero before calibration");

	// Seeking and holding are reached only after calibration.
	a_mode_cal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[1:0] == MODE_SEEK) || (m_tdata[1:0] == MODE_HOLD))
		|-> m_tdata[2])
		else $error("seeking or holding while uncalibrated");

endmodule

bind encoder_stillness_calibrator esc_checker u_esc_checker (.*);
